### sv/assert_macros.svh
// Assertion macros shared by the decoder modules.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GSD_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: check failed");

// The consequent must hold in the cycle after the antecedent.
`define GSD_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

### sv/gsd_pkg.sv
// Package of the signed Golomb decoder: register indexes, reset values,
// output limits and the flag record that travels with each decoded code.
package gsd_pkg;

  localparam int unsigned CfgDataBits = 16;
  localparam int unsigned ValueBits   = 32;

  typedef enum logic [0:0] {
    CFG_DIVISOR   = 1'b0,
    CFG_SIGN_MODE = 1'b1
  } gsd_cfg_idx_e;

  localparam logic [CfgDataBits-1:0] DivisorReset  = 16'd4;
  localparam logic                   SignModeReset = 1'b1;

  localparam logic [63:0] PosLimit = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] NegLimit = 64'h0000_0000_8000_0000;

  typedef struct packed {
    logic zigzag;
    logic negative;
    logic saturated;
  } gsd_flags_t;

endpackage

### sv/gsd_if.sv
// Stream interfaces of the signed Golomb decoder: code bits in, values out.
// No dependencies.
interface gsd_bit_if;
  logic valid;
  logic ready;
  logic code_bit;

  modport source (output valid, output code_bit, input ready);
  modport sink (input valid, input code_bit, output ready);
endinterface

interface gsd_val_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] decoded_value;
  logic               overflow;

  modport source (output valid, output decoded_value, output overflow, input ready);
  modport sink (input valid, input decoded_value, input overflow, output ready);
endinterface

### sv/gsd_front.sv
// Front end of the signed Golomb decoder: parses the code bit stream and
// pushes each complete code to the queue. Uses gsd_pkg and gsd_bit_if.
`include "assert_macros.svh"

module gsd_front #(
  parameter int unsigned QuotientBits = 16,
  parameter int unsigned DivisorBits  = 16,
  parameter int unsigned WidthBits    = 5
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  gsd_bit_if.sink                 code_i,
  input  logic [DivisorBits-1:0]  divisor_i,
  input  logic [WidthBits-1:0]    rem_width_i,
  input  logic                    sign_mode_i,
  input  logic                    full_i,
  output logic                    push_o,
  output gsd_pkg::gsd_flags_t     flags_o,
  output logic [QuotientBits-1:0] quot_o,
  output logic [DivisorBits-1:0]  rem_o,
  output logic [DivisorBits-1:0]  div_o
);

  typedef enum logic [2:0] {
    PH_COUNT = 3'b001,
    PH_REM   = 3'b010,
    PH_SIGN  = 3'b100
  } phase_e;

  phase_e                  phase_q, phase_d;
  logic [QuotientBits-1:0] quot_q, quot_d;
  logic [DivisorBits-1:0]  acc_q, acc_d;
  logic [WidthBits-1:0]    left_q, left_d;
  logic                    sat_q, sat_d;
  logic                    fire;
  logic                    done;
  logic                    clear;

  assign code_i.ready = !full_i;
  assign fire         = code_i.valid && code_i.ready;
  assign quot_o       = quot_q;
  assign div_o        = (divisor_i == '0) ? DivisorBits'(1) : divisor_i;

  always_comb begin
    phase_d = phase_q;
    quot_d  = quot_q;
    acc_d   = acc_q;
    left_d  = left_q;
    sat_d   = sat_q;
    done    = 1'b0;
    clear   = 1'b0;
    push_o  = 1'b0;
    flags_o = '0;
    flags_o.saturated = sat_q;
    if (fire) begin
      unique case (phase_q)
        PH_COUNT: begin
          if (code_i.code_bit) begin
            if (quot_q == '1) begin
              sat_d = 1'b1;
            end else begin
              quot_d = quot_q + QuotientBits'(1);
            end
          end else begin
            acc_d = '0;
            if (rem_width_i != '0) begin
              phase_d = PH_REM;
              left_d  = rem_width_i;
            end else begin
              done = 1'b1;
            end
          end
        end
        PH_REM: begin
          acc_d  = DivisorBits'({acc_q, code_i.code_bit});
          left_d = left_q - WidthBits'(1);
          if (left_q == WidthBits'(1)) begin
            done = 1'b1;
          end
        end
        PH_SIGN: begin
          push_o           = 1'b1;
          flags_o.negative = code_i.code_bit;
          clear            = 1'b1;
        end
        default: begin
          phase_d = PH_COUNT;
        end
      endcase
      if (done) begin
        if (!sign_mode_i) begin
          phase_d = PH_SIGN;
        end else begin
          push_o         = 1'b1;
          flags_o.zigzag = 1'b1;
          clear          = 1'b1;
        end
      end
    end
    rem_o = acc_d;
    if (clear) begin
      phase_d = PH_COUNT;
      quot_d  = '0;
      acc_d   = '0;
      left_d  = '0;
      sat_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_COUNT;
      quot_q  <= '0;
      acc_q   <= '0;
      left_q  <= '0;
      sat_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      quot_q  <= quot_d;
      acc_q   <= acc_d;
      left_q  <= left_d;
      sat_q   <= sat_d;
    end
  end

  `GSD_ASSERT_IMP(a_rem_bits_pending, phase_q == PH_REM, left_q != '0)
  `GSD_ASSERT_IMP(a_push_on_transfer, push_o, fire)

endmodule

### sv/gsd_queue.sv
// Two-entry queue between the front end and the value pipeline.
// Generic payload width; no package dependency.
`include "assert_macros.svh"

module gsd_queue #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [Width-1:0] data_o
);

  logic [Width-1:0] mem_q [2];
  logic             wr_q;
  logic             rd_q;
  logic [1:0]       cnt_q;
  logic             pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign pop     = valid_o && ready_i;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= !wr_q;
      end
      if (pop) begin
        rd_q <= !rd_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop);
    end
  end

  `GSD_ASSERT_IMP(a_no_push_when_full, full_o, !push_i)
  `GSD_ASSERT_NXT(a_pop_drains, pop && !push_i, cnt_q == $past(cnt_q) - 2'd1)

endmodule

### sv/gsd_back.sv
// Value pipeline of the signed Golomb decoder: multiply, sign mapping,
// clamping and the output register. Uses gsd_pkg and gsd_val_if.
`include "assert_macros.svh"

module gsd_back #(
  parameter int unsigned QuotientBits = 16,
  parameter int unsigned DivisorBits  = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  gsd_pkg::gsd_flags_t     flags_i,
  input  logic [QuotientBits-1:0] quot_i,
  input  logic [DivisorBits-1:0]  rem_i,
  input  logic [DivisorBits-1:0]  div_i,
  gsd_val_if.source               result_o
);

  localparam int unsigned ProdBits = QuotientBits + DivisorBits;

  logic                   s1_v_q;
  logic [ProdBits-1:0]    s1_prod_q;
  logic [DivisorBits-1:0] s1_rem_q;
  gsd_pkg::gsd_flags_t    s1_flags_q;

  logic                   s2_v_q;
  logic [ProdBits-1:0]    s2_mag_q;
  logic                   s2_neg_q;
  logic                   s2_sat_q;

  logic                   out_v_q;
  logic [31:0]            out_val_q;
  logic                   out_ov_q;

  logic                   s1_ready, s2_ready, s3_ready;
  logic [ProdBits-1:0]    prod;
  logic [ProdBits-1:0]    v_sum;
  logic [ProdBits-1:0]    mag_d;
  logic                   neg_d;
  logic [63:0]            mag_wide;
  logic [31:0]            val_d;
  logic                   ov_d;

  assign s3_ready = !out_v_q || result_o.ready;
  assign s2_ready = !s2_v_q || s3_ready;
  assign s1_ready = !s1_v_q || s2_ready;
  assign ready_o  = s1_ready;

  assign prod  = ProdBits'(quot_i) * ProdBits'(div_i);
  assign v_sum = s1_prod_q + ProdBits'(s1_rem_q);

  always_comb begin
    if (s1_flags_q.zigzag) begin
      neg_d = v_sum[0];
      mag_d = (v_sum >> 1) + ProdBits'(v_sum[0]);
    end else begin
      neg_d = s1_flags_q.negative;
      mag_d = v_sum;
    end
  end

  always_comb begin
    mag_wide = 64'(s2_mag_q);
    ov_d     = s2_sat_q;
    if (s2_neg_q) begin
      if (mag_wide > gsd_pkg::NegLimit) begin
        val_d = gsd_pkg::NegLimit[31:0];
        ov_d  = 1'b1;
      end else begin
        val_d = 32'(64'd0 - mag_wide);
      end
    end else begin
      if (mag_wide > gsd_pkg::PosLimit) begin
        val_d = gsd_pkg::PosLimit[31:0];
        ov_d  = 1'b1;
      end else begin
        val_d = mag_wide[31:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && s1_ready) begin
      s1_prod_q  <= prod;
      s1_rem_q   <= rem_i;
      s1_flags_q <= flags_i;
    end
    if (s1_v_q && s2_ready) begin
      s2_mag_q <= mag_d;
      s2_neg_q <= neg_d;
      s2_sat_q <= s1_flags_q.saturated;
    end
    if (s2_v_q && s3_ready) begin
      out_val_q <= val_d;
      out_ov_q  <= ov_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_v_q <= valid_i;
      end
      if (s2_ready) begin
        s2_v_q <= s1_v_q;
      end
      if (s3_ready) begin
        out_v_q <= s2_v_q;
      end
    end
  end

  assign result_o.valid         = out_v_q;
  assign result_o.decoded_value = out_val_q;
  assign result_o.overflow      = out_ov_q;

  `GSD_ASSERT_NXT(a_s1_holds, s1_v_q && !s2_ready, s1_v_q)
  `GSD_ASSERT_NXT(a_s2_holds, s2_v_q && !s3_ready, s2_v_q)

endmodule

### sv/golomb_signed_decoder.sv
// A value goes from the queue through the three-stage value pipeline (s1, s2, out) to result_o.
// One code bit per cycle unless the queue is full; one value per cycle unless result_o stalls.
// The two-entry queue between parser and value pipeline absorbs short output stalls.
// Reset clears the parser, the queue and the pipeline valids; divisor returns to 4 and
// sign_mode to zigzag. Configuration writes take effect on the next code bit.
module golomb_signed_decoder #(
  parameter int unsigned QuotientBits = 16,
  parameter int unsigned DivisorBits  = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  gsd_pkg::gsd_cfg_idx_e               cfg_idx_i,
  input  logic [gsd_pkg::CfgDataBits-1:0]     cfg_wdata_i,
  gsd_bit_if.sink                             code_i,
  gsd_val_if.source                           result_o
);

  localparam int unsigned WidthBits = $clog2(DivisorBits + 1);
  localparam int unsigned JobBits   = 3 + QuotientBits + 2 * DivisorBits;

  function automatic logic [WidthBits-1:0] rem_width(input logic [DivisorBits-1:0] m);
    logic [DivisorBits-1:0] m_minus;
    logic [WidthBits-1:0]   w;
    m_minus = (m > DivisorBits'(1)) ? m - DivisorBits'(1) : '0;
    w = '0;
    for (int i = 0; i < DivisorBits; i++) begin
      if (m_minus[i]) begin
        w = WidthBits'(i + 1);
      end
    end
    return w;
  endfunction

  logic [DivisorBits-1:0]  divisor_q;
  logic [WidthBits-1:0]    rem_w_q;
  logic                    sign_mode_q;
  logic [DivisorBits-1:0]  wdata_div;

  logic                    push;
  logic                    full;
  gsd_pkg::gsd_flags_t     push_flags;
  logic [QuotientBits-1:0] push_quot;
  logic [DivisorBits-1:0]  push_rem;
  logic [DivisorBits-1:0]  push_div;
  logic [JobBits-1:0]      push_job;

  logic                    job_valid;
  logic                    job_ready;
  logic [JobBits-1:0]      job;
  gsd_pkg::gsd_flags_t     job_flags;
  logic [QuotientBits-1:0] job_quot;
  logic [DivisorBits-1:0]  job_rem;
  logic [DivisorBits-1:0]  job_div;

  assign wdata_div = DivisorBits'(cfg_wdata_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      divisor_q   <= DivisorBits'(gsd_pkg::DivisorReset);
      rem_w_q     <= rem_width(DivisorBits'(gsd_pkg::DivisorReset));
      sign_mode_q <= gsd_pkg::SignModeReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        gsd_pkg::CFG_DIVISOR: begin
          divisor_q <= wdata_div;
          rem_w_q   <= rem_width(wdata_div);
        end
        gsd_pkg::CFG_SIGN_MODE: begin
          sign_mode_q <= cfg_wdata_i[0];
        end
      endcase
    end
  end

  gsd_front #(
    .QuotientBits(QuotientBits),
    .DivisorBits (DivisorBits),
    .WidthBits   (WidthBits)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .code_i     (code_i),
    .divisor_i  (divisor_q),
    .rem_width_i(rem_w_q),
    .sign_mode_i(sign_mode_q),
    .full_i     (full),
    .push_o     (push),
    .flags_o    (push_flags),
    .quot_o     (push_quot),
    .rem_o      (push_rem),
    .div_o      (push_div)
  );

  assign push_job = {push_flags, push_quot, push_rem, push_div};

  gsd_queue #(
    .Width(JobBits)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_job),
    .full_o (full),
    .valid_o(job_valid),
    .ready_i(job_ready),
    .data_o (job)
  );

  assign {job_flags, job_quot, job_rem, job_div} = job;

  gsd_back #(
    .QuotientBits(QuotientBits),
    .DivisorBits (DivisorBits)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (job_valid),
    .ready_o (job_ready),
    .flags_i (job_flags),
    .quot_i  (job_quot),
    .rem_i   (job_rem),
    .div_i   (job_div),
    .result_o(result_o)
  );

endmodule
